>>> design/ccps_pkg.sv
// Package for the climate chamber plant step: widths, constants, register
// indexes and the transaction payload types.
// No dependencies; every other design file imports it.
package ccps_pkg;

	// Field and register widths.
	localparam int TEMP_W    = 15;
	localparam int HUM_W     = 14;
	localparam int TAU_W     = 16;
	localparam int RATE_W    = 15;
	localparam int TICK_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// Internal datapath widths.
	localparam int LEAK_W = 16;  // Q8 leak factor
	localparam int RSUM_W = 18;  // sum of up to four rates
	localparam int DIFF_W = 17;  // ambient minus chamber value
	localparam int P1_W   = 32;  // difference times leak
	localparam int P2_W   = 34;  // rate sum times time constant
	localparam int MUL_AW = 44;
	localparam int MUL_BW = 18;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int NUM_W  = MUL_PW;
	localparam int DEN_W  = 34;  // time constant times 256000
	localparam int QW     = 30;  // quotient magnitude bits
	localparam int CNT_W  = $clog2(QW);
	localparam int SUM_W  = 32;

	// Leak factors and actuator side effects on humidity.
	localparam logic [LEAK_W-1:0] DOOR_LEAK_Q8      = 16'd2560;
	localparam logic [LEAK_W-1:0] FRESH_AIR_LEAK_Q8 = 16'd768;
	localparam logic [LEAK_W-1:0] UNITY_Q8          = 16'd256;
	localparam logic signed [RATE_W-1:0] COOL_DRYING_RATE = 15'sd0;
	localparam logic signed [RATE_W-1:0] HEAT_DRYING_RATE = 15'sd0;

	// Divisor scale: 256 for the Q8 leak times 1000 ms per second.
	localparam logic signed [MUL_AW-1:0] DEN_SCALE = 44'sd256000;

	// Clamp bounds in hundredths.
	localparam logic signed [SUM_W-1:0] TEMP_MIN = -32'sd4000;
	localparam logic signed [SUM_W-1:0] TEMP_MAX = 32'sd9000;
	localparam logic signed [SUM_W-1:0] HUM_MIN  = 32'sd0;
	localparam logic signed [SUM_W-1:0] HUM_MAX  = 32'sd10000;

	// Reset values.
	localparam logic signed [TEMP_W-1:0] TEMP_RESET = 15'sd2000;
	localparam logic [HUM_W-1:0]         HUM_RESET  = 14'd5000;
	localparam logic [TAU_W-1:0]         TAU_RESET  = 16'd600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMBIENT_TEMPERATURE    = 3'd0,
		REG_AMBIENT_HUMIDITY       = 3'd1,
		REG_THERMAL_TIME_CONSTANT  = 3'd2,
		REG_HUMIDITY_TIME_CONSTANT = 3'd3,
		REG_COOLING_RATE           = 3'd4,
		REG_HEATING_RATE           = 3'd5,
		REG_HUMIDIFYING_RATE       = 3'd6,
		REG_DEHUMIDIFYING_RATE     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic              cool_cmd;
		logic              heat_cmd;
		logic              humidify_cmd;
		logic              dehumidify_cmd;
		logic              fresh_air_cmd;
		logic              door_is_open;
		logic [TICK_W-1:0] tick_ms;
		logic              cooler_failed;
		logic              heater_failed;
		logic              humidifier_failed;
		logic              dehumidifier_failed;
	} tick_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] new_temperature;
		logic [HUM_W-1:0]         new_humidity;
	} result_t;

endpackage

>>> design/ccps_mul.sv
// Shared signed multiplier of the plant step datapath.
// Depends on ccps_pkg for the operand widths.
module ccps_mul import ccps_pkg::*; (
	input  logic signed [MUL_AW-1:0] a,
	input  logic signed [MUL_BW-1:0] b,
	output logic signed [MUL_PW-1:0] p
);

	assign p = MUL_PW'(a) * MUL_PW'(b);

endmodule

>>> design/ccps_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on ccps_pkg for widths; the caller guarantees the quotient fits QW bits.
module ccps_div import ccps_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [QW:0]      quo
);

	localparam int DSH_W = DEN_W + QW - 1;

	logic [NUM_W-1:0] rem_q;
	logic [DSH_W-1:0] dsh_q;
	logic [QW-1:0]    mag_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DSH_W:0]   trial;
	logic             take;

	assign trial = {1'b0, DSH_W'(rem_q)} - {1'b0, dsh_q};
	assign take  = !trial[DSH_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			rem_q <= num[NUM_W-1] ? unsigned'(-num) : unsigned'(num);
			dsh_q <= {den, {(QW - 1){1'b0}}};
			mag_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= trial[NUM_W-1:0];
			end
			mag_q <= {mag_q[QW-2:0], take};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -signed'({1'b0, mag_q}) : signed'({1'b0, mag_q});

endmodule

>>> design/climate_chamber_plant_step.sv
// Climate chamber plant step: top level with configuration registers,
// chamber state, sequencer and result register. Depends on ccps_pkg,
// ccps_mul and ccps_div.
//
// Usage:
//   tick_valid/tick_ready/tick_data carry one simulation tick per transaction.
//   result_valid/result_ready/result_data return the updated temperature and
//   humidity, one result transaction per tick, in order.
//   cfg_we/cfg_index/cfg_data write the eight registers, one per cycle.
// Timing:
//   The temperature and then the humidity pass through the same multiplier
//   (four products each) and the same 30-step divider. tick_ready is high
//   again from the cycle in which result_valid rises, so the block takes a
//   new tick only once the previous one has finished.
// Reset:
//   arst_n clears the registers to their defaults, the chamber to 20.00 degC
//   and 50.00 %, and leaves the result register empty.
// Stalls:
//   A result waits in the result register while the next tick is taken. If
//   the next result is ready before the old one is taken, the sequencer holds
//   until result_ready frees the register.
module climate_chamber_plant_step import ccps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_valid,
	output logic                 tick_ready,
	input  tick_t                tick_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MDIFF  = 8'b0000_0010,
		ST_MRATE  = 8'b0000_0100,
		ST_MDEN   = 8'b0000_1000,
		ST_MNUM   = 8'b0001_0000,
		ST_DSTART = 8'b0010_0000,
		ST_DIV    = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} state_t;

	// Configuration registers.
	logic signed [TEMP_W-1:0] ambient_temperature_q;
	logic [HUM_W-1:0]         ambient_humidity_q;
	logic [TAU_W-1:0]         thermal_time_constant_q;
	logic [TAU_W-1:0]         humidity_time_constant_q;
	logic signed [RATE_W-1:0] cooling_rate_q;
	logic signed [RATE_W-1:0] heating_rate_q;
	logic signed [RATE_W-1:0] humidifying_rate_q;
	logic signed [RATE_W-1:0] dehumidifying_rate_q;

	// Chamber state and sequencer.
	logic signed [TEMP_W-1:0] chamber_temperature_q;
	logic [HUM_W-1:0]         chamber_humidity_q;
	state_t                   state_q;
	logic                     phase_q;  // low: temperature, high: humidity
	logic                     result_valid_q;
	result_t                  result_q;

	// Per-tick operands and intermediate products.
	logic [LEAK_W-1:0]        leak_q;
	logic signed [RSUM_W-1:0] trate_q;
	logic signed [RSUM_W-1:0] hrate_q;
	logic [TICK_W-1:0]        tick_q;
	logic signed [P1_W-1:0]   p1_q;
	logic signed [P2_W-1:0]   p2_q;
	logic signed [MUL_AW-1:0] sum_q;
	logic [DEN_W-1:0]         den_q;
	logic signed [NUM_W-1:0]  num_q;

	logic                     tick_acc;
	logic                     cool_on, heat_on, humidify_on, dehumidify_on;
	logic [LEAK_W-1:0]        leak_sel;
	logic signed [RSUM_W-1:0] trate_sel, hrate_sel;
	logic signed [DIFF_W-1:0] x_s, a_s, diff_s;
	logic [TAU_W-1:0]         tau_sel, tau_eff;
	logic signed [RSUM_W-1:0] rate_sel;
	logic signed [MUL_AW-1:0] mul_a;
	logic signed [MUL_BW-1:0] mul_b;
	logic signed [MUL_PW-1:0] mul_p;
	logic                     div_start, div_done;
	logic signed [QW:0]       div_quo;
	logic signed [SUM_W-1:0]  x_next, lo_b, hi_b, x_clamped;
	logic                     out_free;

	assign tick_acc = tick_valid && tick_ready;
	assign out_free = !result_valid_q || result_ready;

	// Actuators that have failed are masked before the rates are summed.
	assign cool_on       = tick_data.cool_cmd && !tick_data.cooler_failed;
	assign heat_on       = tick_data.heat_cmd && !tick_data.heater_failed;
	assign humidify_on   = tick_data.humidify_cmd && !tick_data.humidifier_failed;
	assign dehumidify_on = tick_data.dehumidify_cmd && !tick_data.dehumidifier_failed;

	always_comb begin
		// An open door overrides the fresh-air leak.
		if (tick_data.door_is_open) begin
			leak_sel = DOOR_LEAK_Q8;
		end else if (tick_data.fresh_air_cmd) begin
			leak_sel = FRESH_AIR_LEAK_Q8;
		end else begin
			leak_sel = UNITY_Q8;
		end
		trate_sel = '0;
		hrate_sel = '0;
		if (cool_on) begin
			trate_sel = trate_sel + RSUM_W'(cooling_rate_q);
			hrate_sel = hrate_sel + RSUM_W'(COOL_DRYING_RATE);
		end
		if (heat_on) begin
			trate_sel = trate_sel + RSUM_W'(heating_rate_q);
			hrate_sel = hrate_sel + RSUM_W'(HEAT_DRYING_RATE);
		end
		if (humidify_on) begin
			hrate_sel = hrate_sel + RSUM_W'(humidifying_rate_q);
		end
		if (dehumidify_on) begin
			hrate_sel = hrate_sel + RSUM_W'(dehumidifying_rate_q);
		end
	end

	// Operands of the quantity being worked on.
	always_comb begin
		if (phase_q) begin
			x_s      = signed'(DIFF_W'(chamber_humidity_q));
			a_s      = signed'(DIFF_W'(ambient_humidity_q));
			tau_sel  = humidity_time_constant_q;
			rate_sel = hrate_q;
			lo_b     = HUM_MIN;
			hi_b     = HUM_MAX;
		end else begin
			x_s      = DIFF_W'(chamber_temperature_q);
			a_s      = DIFF_W'(ambient_temperature_q);
			tau_sel  = thermal_time_constant_q;
			rate_sel = trate_q;
			lo_b     = TEMP_MIN;
			hi_b     = TEMP_MAX;
		end
		diff_s  = a_s - x_s;
		// A zero time constant counts as one second.
		tau_eff = (tau_sel == '0) ? TAU_W'(1) : tau_sel;
	end

	always_comb begin
		case (state_q)
			ST_MDIFF: begin
				mul_a = MUL_AW'(diff_s);
				mul_b = signed'(MUL_BW'(leak_q));
			end
			ST_MRATE: begin
				mul_a = MUL_AW'(rate_sel);
				mul_b = signed'(MUL_BW'(tau_eff));
			end
			ST_MDEN: begin
				mul_a = DEN_SCALE;
				mul_b = signed'(MUL_BW'(tau_eff));
			end
			ST_MNUM: begin
				mul_a = sum_q;
				mul_b = signed'(MUL_BW'(tick_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ccps_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	assign div_start = (state_q == ST_DSTART);

	ccps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		x_next = SUM_W'(x_s) + SUM_W'(div_quo);
		if (x_next < lo_b) begin
			x_clamped = lo_b;
		end else if (x_next > hi_b) begin
			x_clamped = hi_b;
		end else begin
			x_clamped = x_next;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambient_temperature_q    <= TEMP_RESET;
			ambient_humidity_q       <= HUM_RESET;
			thermal_time_constant_q  <= TAU_RESET;
			humidity_time_constant_q <= TAU_RESET;
			cooling_rate_q           <= '0;
			heating_rate_q           <= '0;
			humidifying_rate_q       <= '0;
			dehumidifying_rate_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_AMBIENT_TEMPERATURE:    ambient_temperature_q <= cfg_data[TEMP_W-1:0];
				REG_AMBIENT_HUMIDITY:       ambient_humidity_q <= cfg_data[HUM_W-1:0];
				REG_THERMAL_TIME_CONSTANT:  thermal_time_constant_q <= cfg_data[TAU_W-1:0];
				REG_HUMIDITY_TIME_CONSTANT: humidity_time_constant_q <= cfg_data[TAU_W-1:0];
				REG_COOLING_RATE:           cooling_rate_q <= cfg_data[RATE_W-1:0];
				REG_HEATING_RATE:           heating_rate_q <= cfg_data[RATE_W-1:0];
				REG_HUMIDIFYING_RATE:       humidifying_rate_q <= cfg_data[RATE_W-1:0];
				REG_DEHUMIDIFYING_RATE:     dehumidifying_rate_q <= cfg_data[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, chamber state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q               <= ST_IDLE;
			phase_q               <= 1'b0;
			result_valid_q        <= 1'b0;
			chamber_temperature_q <= TEMP_RESET;
			chamber_humidity_q    <= HUM_RESET;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						phase_q <= 1'b0;
						state_q <= ST_MDIFF;
					end
				end
				ST_MDIFF:  state_q <= ST_MRATE;
				ST_MRATE:  state_q <= ST_MDEN;
				ST_MDEN:   state_q <= ST_MNUM;
				ST_MNUM:   state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!phase_q) begin
						chamber_temperature_q <= x_clamped[TEMP_W-1:0];
						phase_q               <= 1'b1;
						state_q               <= ST_MDIFF;
					end else if (out_free) begin
						chamber_humidity_q <= x_clamped[HUM_W-1:0];
						result_valid_q     <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			leak_q  <= leak_sel;
			trate_q <= trate_sel;
			hrate_q <= hrate_sel;
			tick_q  <= tick_data.tick_ms;
		end
		case (state_q)
			ST_MDIFF: p1_q <= mul_p[P1_W-1:0];
			ST_MRATE: p2_q <= mul_p[P2_W-1:0];
			ST_MDEN: begin
				den_q <= mul_p[DEN_W-1:0];
				sum_q <= MUL_AW'(p1_q) + (MUL_AW'(p2_q) <<< 8);
			end
			ST_MNUM: num_q <= mul_p;
			ST_FIN: begin
				if (phase_q && out_free) begin
					result_q.new_temperature <= chamber_temperature_q;
					result_q.new_humidity    <= x_clamped[HUM_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign tick_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

>>> design/ccps_checker.sv
// Port-level checker for the climate chamber plant step, bound to the top level.
// Depends on ccps_pkg and on the climate_chamber_plant_step port list.
module ccps_checker import ccps_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    tick_valid,
	input logic    tick_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result_data
);

	// A result that is not taken holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// Results always lie inside the clamp bounds.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $signed(result_data.new_temperature) >= -16'sd4000
			&& $signed(result_data.new_temperature) <= 16'sd9000
			&& result_data.new_humidity <= 14'd10000)
		else $error("result outside clamp bounds");

	// The block works on one tick at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("tick taken while the previous one is in progress");

	// Finishing a tick frees the input side in the same cycle.
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> tick_ready)
		else $error("result appeared without the block returning to idle");

endmodule

bind climate_chamber_plant_step ccps_checker u_ccps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick_valid),
	.tick_ready   (tick_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for climate_chamber_plant_step: a scoreboard class
// predicts each chamber reading, plain tasks drive ticks and register writes.
// Depends on ccps_pkg and the climate_chamber_plant_step design files.
module testbench;
	import ccps_pkg::*;

	localparam int PHASES        = 8;
	localparam int PHASE_TICKS   = 250;
	localparam int SETTLE_CYCLES = 80;
	localparam int CYCLE_LIMIT   = 3_000_000;

	class chamber_scoreboard;
		logic signed [TEMP_W-1:0] amb_temp;
		logic [HUM_W-1:0]         amb_hum;
		logic [TAU_W-1:0]         tau_temp;
		logic [TAU_W-1:0]         tau_hum;
		logic signed [RATE_W-1:0] cooling_rate;
		logic signed [RATE_W-1:0] heating_rate;
		logic signed [RATE_W-1:0] humidifying_rate;
		logic signed [RATE_W-1:0] dehumidifying_rate;
		logic signed [TEMP_W-1:0] chamber_temp;
		logic [HUM_W-1:0]         chamber_hum;
		result_t                  expected_readings [$];
		int                       ticks_seen;
		int                       results_seen;
		int                       errors;

		function new();
			amb_temp = TEMP_RESET;
			amb_hum = HUM_RESET;
			tau_temp = TAU_RESET;
			tau_hum = TAU_RESET;
			cooling_rate = '0;
			heating_rate = '0;
			humidifying_rate = '0;
			dehumidifying_rate = '0;
			chamber_temp = TEMP_RESET;
			chamber_hum = HUM_RESET;
			ticks_seen = 0;
			results_seen = 0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_AMBIENT_TEMPERATURE:    amb_temp = v[TEMP_W-1:0];
				REG_AMBIENT_HUMIDITY:       amb_hum = v[HUM_W-1:0];
				REG_THERMAL_TIME_CONSTANT:  tau_temp = v[TAU_W-1:0];
				REG_HUMIDITY_TIME_CONSTANT: tau_hum = v[TAU_W-1:0];
				REG_COOLING_RATE:           cooling_rate = v[RATE_W-1:0];
				REG_HEATING_RATE:           heating_rate = v[RATE_W-1:0];
				REG_HUMIDIFYING_RATE:       humidifying_rate = v[RATE_W-1:0];
				REG_DEHUMIDIFYING_RATE:     dehumidifying_rate = v[RATE_W-1:0];
				default: ;
			endcase
		endfunction

		// One quotient per quantity, truncated toward zero, then clamped.
		function longint settle_toward_ambient(longint x, longint amb, longint tau,
				longint leak, longint rate, longint ms, longint lo, longint hi);
			longint num, den, y;
			if (tau < 1)
				tau = 1;
			num = (amb - x) * leak * ms + rate * tau * longint'(UNITY_Q8) * ms;
			den = tau * longint'(UNITY_Q8) * 1000;
			y = x + num / den;
			if (y < lo)
				y = lo;
			else if (y > hi)
				y = hi;
			return y;
		endfunction

		function void note_tick(tick_t t);
			logic   cool, heat, wet, dry;
			longint leak, t_rate, h_rate;
			result_t want;
			cool = t.cool_cmd & ~t.cooler_failed;
			heat = t.heat_cmd & ~t.heater_failed;
			wet  = t.humidify_cmd & ~t.humidifier_failed;
			dry  = t.dehumidify_cmd & ~t.dehumidifier_failed;
			// An open door overrides the fresh-air leak.
			if (t.door_is_open)
				leak = longint'(DOOR_LEAK_Q8);
			else if (t.fresh_air_cmd)
				leak = longint'(FRESH_AIR_LEAK_Q8);
			else
				leak = longint'(UNITY_Q8);
			t_rate = 0;
			h_rate = 0;
			if (cool) begin
				t_rate += longint'(cooling_rate);
				h_rate += longint'(COOL_DRYING_RATE);
			end
			if (heat) begin
				t_rate += longint'(heating_rate);
				h_rate += longint'(HEAT_DRYING_RATE);
			end
			if (wet)
				h_rate += longint'(humidifying_rate);
			if (dry)
				h_rate += longint'(dehumidifying_rate);
			chamber_temp = TEMP_W'(settle_toward_ambient(longint'(chamber_temp),
				longint'(amb_temp), longint'(tau_temp), leak, t_rate,
				longint'(t.tick_ms), longint'(TEMP_MIN), longint'(TEMP_MAX)));
			chamber_hum = HUM_W'(settle_toward_ambient(longint'(chamber_hum),
				longint'(amb_hum), longint'(tau_hum), leak, h_rate,
				longint'(t.tick_ms), longint'(HUM_MIN), longint'(HUM_MAX)));
			want.new_temperature = chamber_temp;
			want.new_humidity = chamber_hum;
			expected_readings.push_back(want);
			ticks_seen++;
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected result, temperature %0d humidity %0d", $time,
					$signed(got.new_temperature), got.new_humidity);
				errors++;
				return;
			end
			want = expected_readings.pop_front();
			if (got.new_temperature !== want.new_temperature) begin
				$display("%0t: new_temperature expected %0d, actual %0d", $time,
					$signed(want.new_temperature), $signed(got.new_temperature));
				errors++;
			end
			if (got.new_humidity !== want.new_humidity) begin
				$display("%0t: new_humidity expected %0d, actual %0d", $time,
					want.new_humidity, got.new_humidity);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 tick_valid = 1'b0;
	logic                 tick_ready;
	tick_t                tick_data = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	result_t              result_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	chamber_scoreboard sb;
	int                source_gap_pct = 0;
	int                sink_busy_pct = 0;
	logic [3:0]        stall_left = '0;
	int                cycle_count = 0;
	int                settings_used = 1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	climate_chamber_plant_step i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_ready   (tick_ready),
		.tick_data    (tick_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Result side: ready drops in bursts; a high busy percentage chains bursts
	// so that a finished result can wait through the next computation.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1'b1;
			result_ready <= 1'b0;
		end else if (sink_busy_pct != 0 && $urandom_range(0, 99) < sink_busy_pct) begin
			stall_left <= 4'($urandom_range(0, 12));
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && tick_valid && tick_ready)
			sb.note_tick(tick_data);
		if (arst_n && result_valid && result_ready)
			sb.check_result(result_data);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout with %0d results outstanding", $time,
			sb.expected_readings.size());
		$display("climate_chamber_plant_step: mismatch");
		$finish;
	end

	function automatic tick_t tk(logic [5:0] cmds, logic [15:0] ms, logic [3:0] fails);
		return {cmds, ms, fails};
	endfunction

	function automatic tick_t rand_tick();
		tick_t t;
		t = tick_t'($urandom);
		t.door_is_open = ($urandom_range(0, 3) == 0);
		t.cooler_failed = ($urandom_range(0, 7) == 0);
		t.heater_failed = ($urandom_range(0, 7) == 0);
		t.humidifier_failed = ($urandom_range(0, 7) == 0);
		t.dehumidifier_failed = ($urandom_range(0, 7) == 0);
		case ($urandom_range(0, 9))
			0: t.tick_ms = '0;
			1: ;
			2, 3, 4: t.tick_ms = 16'($urandom_range(1, 2000));
			default: t.tick_ms = 16'($urandom_range(0, 60000));
		endcase
		return t;
	endfunction

	function automatic logic [CFG_W-1:0] rand_reg(cfg_reg_t idx);
		int pick, v;
		pick = $urandom_range(0, 9);
		case (idx)
			REG_AMBIENT_TEMPERATURE: begin
				case (pick)
					0: v = 9000;
					1: v = -4000;
					2: v = $urandom;
					default: v = int'($urandom_range(0, 13000)) - 4000;
				endcase
			end
			REG_AMBIENT_HUMIDITY: begin
				case (pick)
					0: v = 10000;
					1: v = 0;
					2: v = $urandom;
					default: v = $urandom_range(0, 10000);
				endcase
			end
			REG_THERMAL_TIME_CONSTANT, REG_HUMIDITY_TIME_CONSTANT: begin
				case (pick)
					0: v = 0;
					1: v = 1;
					2: v = 65535;
					3: v = $urandom;
					default: v = $urandom_range(1, 2000);
				endcase
			end
			default: begin
				case (pick)
					0: v = 10000;
					1: v = -10000;
					2: v = $urandom;
					3: v = 0;
					default: v = int'($urandom_range(0, 4000)) - 2000;
				endcase
			end
		endcase
		return v[CFG_W-1:0];
	endfunction

	// Valid stays high across back-to-back ticks; it is lowered only before
	// an idle stretch.
	task automatic send_tick(tick_t t);
		int bursts;
		if (source_gap_pct != 0 && $urandom_range(0, 99) < source_gap_pct) begin
			tick_valid <= 1'b0;
			bursts = $urandom_range(1, 6);
			repeat (bursts)
				repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick_data <= t;
		do
			@(posedge clk);
		while (!tick_ready);
	endtask

	// Waits until every reading has come back and the block has gone quiet.
	task automatic drain();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(cfg_reg_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	initial begin
		logic [CFG_W-1:0] vals [8];
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: rates are zero and the chamber sits at ambient.
		source_gap_pct = 30;
		sink_busy_pct = 20;
		send_tick(tk(6'b000000, 16'd0, 4'b0000));
		send_tick(tk(6'b111111, 16'hFFFF, 4'b1111));
		drain();

		vals = '{16'd3500, 16'd8000, 16'd60, 16'd30,
			-16'sd300, 16'sd250, 16'sd120, -16'sd90};
		program_regs(vals);
		send_tick(tk(6'b000000, 16'd1000, 4'b0000));
		send_tick(tk(6'b000010, 16'd1000, 4'b0000));
		send_tick(tk(6'b000001, 16'd1000, 4'b0000));
		send_tick(tk(6'b000011, 16'd1000, 4'b0000));
		send_tick(tk(6'b100000, 16'd60000, 4'b0000));
		send_tick(tk(6'b010000, 16'd60000, 4'b0000));
		send_tick(tk(6'b001000, 16'd60000, 4'b0000));
		send_tick(tk(6'b000100, 16'd60000, 4'b0000));
		send_tick(tk(6'b111100, 16'd60000, 4'b1111));
		send_tick(tk(6'b100000, 16'd60000, 4'b1000));
		send_tick(tk(6'b010000, 16'd5000, 4'b0100));
		send_tick(tk(6'b001000, 16'd5000, 4'b0010));
		send_tick(tk(6'b000100, 16'd5000, 4'b0001));
		send_tick(tk(6'b110000, 16'd65535, 4'b0000));
		drain();

		// Register extremes: zero thermal time constant, humidity ambient
		// above full scale, rates at both ends of their range.
		vals = '{16'h3FFF, 16'h3FFF, 16'd0, 16'hFFFF,
			16'h4000, 16'h3FFF, 16'h3FFF, 16'h4000};
		program_regs(vals);
		send_tick(tk(6'b010001, 16'd60000, 4'b0000));
		send_tick(tk(6'b001000, 16'd60000, 4'b0000));
		send_tick(tk(6'b100000, 16'd60000, 4'b0000));
		send_tick(tk(6'b000100, 16'd60000, 4'b0000));
		send_tick(tk(6'b000011, 16'd65535, 4'b0000));
		send_tick(tk(6'b000000, 16'd1, 4'b0000));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			for (int i = 0; i < 8; i++)
				vals[i] = rand_reg(cfg_reg_t'(i));
			program_regs(vals);
			if (p == PHASES - 1) begin
				source_gap_pct = 0;
				sink_busy_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: source_gap_pct = 0;
					1: source_gap_pct = 15;
					2: source_gap_pct = 50;
					default: source_gap_pct = 90;
				endcase
				case ($urandom_range(0, 3))
					0: sink_busy_pct = 0;
					1: sink_busy_pct = 10;
					2: sink_busy_pct = 60;
					default: sink_busy_pct = 95;
				endcase
			end
			repeat (PHASE_TICKS) send_tick(rand_tick());
			drain();
		end

		if (sb.expected_readings.size() != 0) begin
			$display("%0t: %0d readings never arrived", $time, sb.expected_readings.size());
			sb.errors += sb.expected_readings.size();
		end
		$display("Sent %0d ticks under %0d register settings, with idle and stall bursts.",
			sb.ticks_seen, settings_used);
		$display("Compared %0d readings field by field in %0d cycles.",
			sb.results_seen, cycle_count);
		if (sb.errors == 0)
			$display("climate_chamber_plant_step: match");
		else
			$display("climate_chamber_plant_step: mismatch");
		$finish;
	end

endmodule

>>> sim.f
design/ccps_pkg.sv
design/ccps_mul.sv
design/ccps_div.sv
design/climate_chamber_plant_step.sv
design/ccps_checker.sv
verif/testbench.sv
